// ===== rtl/core/grpt_pkg.sv =====
// shared types and constants of the rectangle placement table
`default_nettype none
package grpt_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_MOVE   = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_FREE   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  localparam logic CFG_GRID_W = 1'b0;
  localparam logic CFG_GRID_H = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] entry_id;
    logic [3:0]  pos_x;
    logic [3:0]  pos_y;
    logic [4:0]  size_x;
    logic [4:0]  size_y;
    logic        rotated;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_entry_id;
    logic [3:0]  out_pos_x;
    logic [3:0]  out_pos_y;
    logic [4:0]  out_size_x;
    logic [4:0]  out_size_y;
    logic        out_rotated;
  } rsp_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [4:0]  w;
    logic [4:0]  h;
    logic        rot;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_CHECK,
    FSM_NEXTPOS,
    FSM_DONE
  } fsm_e;

endpackage
`default_nettype wire

// ===== rtl/core/grpt_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module grpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/grid_rectangle_placement_table.sv =====
// remove and find take one lookup pass over the table; add and move (once its entry is found) a
// lookup pass and then a check pass; find free a lookup pass and one check pass per candidate
// position; each pass reads one table entry a cycle from a single-port memory, so the entry
// scan sets the rate; one request at a time; results appear for one cycle on done_o and cannot be stalled
// reset: no entry valid, id counter zero, grid 16 by 16; no clearing pass
`default_nettype none
module grid_rectangle_placement_table #(
  parameter int unsigned MaxEntries = 16,
  parameter int unsigned GridMax    = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire grpt_pkg::req_t  req_i,
  output logic                 done_o,
  output grpt_pkg::rsp_t       rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [4:0]      cfg_data_i
);
  import grpt_pkg::*;

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam logic [4:0] GridMaxC = (GridMax >= 16) ? 5'd16 : 5'(GridMax);

  fsm_e state_q, state_d;
  req_t req_q;
  logic [4:0] gw_q, gh_q;
  logic [MaxEntries-1:0] valid_q;
  logic [15:0] next_id_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] hit_q;         // slot found by lookup
  logic hit_ok_q;
  logic clash_q;
  logic [3:0] cx_q, cy_q;         // candidate position
  logic [4:0] fw_q, fh_q;         // candidate footprint
  logic [1:0] phase_q;            // 0 lookup, 1 check
  rsp_t rsp_q, rsp_d;
  logic done_q;
  entry_t entry_q;                // copy of the looked-up entry

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  entry_t ram_wdata, ram_rdata;

  grpt_ram #(.Width(EntryW), .Depth(1 << IdxW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [4:0] egw, egh;
  assign egw = (gw_q > GridMaxC) ? GridMaxC : gw_q;
  assign egh = (gh_q > GridMaxC) ? GridMaxC : gh_q;

  // the entry read last cycle has index cnt_q - 1
  logic [IdxW-1:0] rd_idx;
  logic rd_live;
  assign rd_idx  = IdxW'(cnt_q - CntW'(1));
  assign rd_live = (cnt_q != '0) && valid_q[rd_idx];

  logic [4:0] ow, oh;
  logic [5:0] cx_end, cy_end, ox_end, oy_end;
  logic overlap;
  always_comb begin
    ow = ram_rdata.rot ? ram_rdata.h : ram_rdata.w;
    oh = ram_rdata.rot ? ram_rdata.w : ram_rdata.h;
    cx_end = {2'b0, cx_q} + {1'b0, fw_q};
    cy_end = {2'b0, cy_q} + {1'b0, fh_q};
    ox_end = {2'b0, ram_rdata.x} + {1'b0, ow};
    oy_end = {2'b0, ram_rdata.y} + {1'b0, oh};
    overlap = !((cx_end <= {2'b0, ram_rdata.x}) || (ox_end <= {2'b0, cx_q}) ||
                (cy_end <= {2'b0, ram_rdata.y}) || (oy_end <= {2'b0, cy_q}));
  end

  logic fits_grid;
  assign fits_grid = (fw_q != 5'd0) && (fh_q != 5'd0) &&
                     (cx_end <= {1'b0, egw}) && (cy_end <= {1'b0, egh});

  // footprint check before the check pass (fw/fh known after lookup)
  logic fits_grid_pre;
  assign fits_grid_pre = !(req_q.req_type == REQ_ADD || req_q.req_type == REQ_FREE ||
                           (req_q.req_type == REQ_MOVE && hit_ok_q)) || fits_grid;

  logic free_any;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  logic scan_end;
  assign scan_end = (cnt_q == CntW'(MaxEntries));
  logic clash_now;
  assign clash_now = clash_q ||
    (rd_live && overlap && !(req_q.req_type == REQ_MOVE && rd_idx == hit_q));

  // next candidate for the free search
  logic [5:0] nx_end, ny_end;
  assign nx_end = {2'b0, cx_q} + 6'd1 + {1'b0, fw_q};
  assign ny_end = {2'b0, cy_q} + 6'd1 + {1'b0, fh_q};

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    case (state_q)
      FSM_IDLE: begin
        if (start) begin
          cnt_d = '0;
          state_d = FSM_LOOKUP;
        end
      end
      FSM_LOOKUP, FSM_CHECK: begin
        cnt_d = cnt_q + CntW'(1);
        if (scan_end) state_d = FSM_NEXTPOS;
      end
      FSM_NEXTPOS: begin
        cnt_d = '0;
        state_d = FSM_DONE;
        if (phase_q == 2'd0 && hit_ok_q &&
            (req_q.req_type == REQ_MOVE || req_q.req_type == REQ_FIND)) begin
          state_d = (req_q.req_type == REQ_FIND) ? FSM_DONE : FSM_CHECK;
        end else if (phase_q == 2'd0 && (req_q.req_type == REQ_ADD ||
                                         req_q.req_type == REQ_FREE)) begin
          state_d = FSM_CHECK;
        end else if (phase_q == 2'd1 && req_q.req_type == REQ_FREE && clash_q &&
                     fits_grid) begin
          state_d = FSM_CHECK;
        end
        if (phase_q == 2'd0 && !fits_grid_pre) state_d = FSM_DONE;
      end
      FSM_DONE: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  // result of the pass that ends in this cycle
  always_comb begin
    rsp_d = '0;
    rsp_d.status = ST_REJECT;
    case (req_q.req_type)
      REQ_REMOVE: if (hit_ok_q) rsp_d.status = ST_OK;
      REQ_FIND: begin
        if (hit_ok_q) begin
          rsp_d.status = ST_OK;
          rsp_d.out_entry_id = entry_q.id;
          rsp_d.out_pos_x = entry_q.x;
          rsp_d.out_pos_y = entry_q.y;
          rsp_d.out_size_x = entry_q.w;
          rsp_d.out_size_y = entry_q.h;
          rsp_d.out_rotated = entry_q.rot;
        end
      end
      REQ_MOVE: if (phase_q == 2'd1 && !clash_q && fits_grid) rsp_d.status = ST_OK;
      REQ_ADD: begin
        if (phase_q == 2'd1 && !clash_q && fits_grid) begin
          rsp_d.status = free_any ? ST_OK : ST_FULL;
          if (free_any) rsp_d.out_entry_id = next_id_q;
        end
      end
      REQ_FREE: begin
        if (phase_q == 2'd1 && !clash_q && fits_grid) begin
          rsp_d.status = ST_OK;
          rsp_d.out_pos_x = cx_q;
          rsp_d.out_pos_y = cy_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = IdxW'(cnt_q);
    ram_wdata = ram_rdata;
    if (state_q == FSM_DONE && rsp_q.status == ST_OK) begin
      if (req_q.req_type == REQ_ADD) begin
        ram_we = 1'b1;
        ram_addr = free_idx;
        ram_wdata = '{id: next_id_q, x: req_q.pos_x, y: req_q.pos_y,
                      w: req_q.size_x, h: req_q.size_y, rot: req_q.rotated};
      end else if (req_q.req_type == REQ_MOVE) begin
        ram_we = 1'b1;
        ram_addr = hit_q;
        ram_wdata = entry_q;
        ram_wdata.x = req_q.pos_x;
        ram_wdata.y = req_q.pos_y;
        ram_wdata.rot = req_q.rotated;
      end
    end
    if (state_q == FSM_NEXTPOS || state_q == FSM_IDLE) ram_addr = hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      gw_q <= 5'd16;
      gh_q <= 5'd16;
      valid_q <= '0;
      next_id_q <= '0;
      cnt_q <= '0;
      done_q <= 1'b0;
      phase_q <= 2'd0;
      hit_ok_q <= 1'b0;
      clash_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRID_W) gw_q <= cfg_data_i;
        else gh_q <= cfg_data_i;
      end
      case (state_q)
        FSM_IDLE: begin
          if (start) begin
            phase_q <= 2'd0;
            hit_ok_q <= 1'b0;
            clash_q <= 1'b0;
          end
        end
        FSM_LOOKUP: begin
          if (!hit_ok_q && rd_live && ram_rdata.id == req_q.entry_id) hit_ok_q <= 1'b1;
        end
        FSM_CHECK: begin
          if (cnt_q != '0) clash_q <= clash_now;
        end
        FSM_NEXTPOS: begin
          clash_q <= 1'b0;
          phase_q <= 2'd1;
        end
        FSM_DONE: begin
          done_q <= 1'b1;
          if (rsp_q.status == ST_OK) begin
            if (req_q.req_type == REQ_ADD) begin
              valid_q[free_idx] <= 1'b1;
              next_id_q <= next_id_q + 16'd1;
            end else if (req_q.req_type == REQ_REMOVE) begin
              valid_q[hit_q] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_IDLE && start) begin
      req_q <= req_i;
      cx_q <= (req_i.req_type == REQ_FREE) ? 4'd0 : req_i.pos_x;
      cy_q <= (req_i.req_type == REQ_FREE) ? 4'd0 : req_i.pos_y;
      fw_q <= (req_i.rotated && req_i.req_type == REQ_ADD) ? req_i.size_y : req_i.size_x;
      fh_q <= (req_i.rotated && req_i.req_type == REQ_ADD) ? req_i.size_x : req_i.size_y;
    end
    if (state_q == FSM_LOOKUP && !hit_ok_q && rd_live &&
        ram_rdata.id == req_q.entry_id) begin
      hit_q <= rd_idx;
      entry_q <= ram_rdata;
      if (req_q.req_type == REQ_MOVE) begin
        fw_q <= req_q.rotated ? ram_rdata.h : ram_rdata.w;
        fh_q <= req_q.rotated ? ram_rdata.w : ram_rdata.h;
      end
    end
    if (state_q == FSM_NEXTPOS) begin
      rsp_q <= rsp_d;
      if (phase_q == 2'd1 && req_q.req_type == REQ_FREE && clash_q) begin
        if (nx_end <= {1'b0, egw}) begin
          cx_q <= cx_q + 4'd1;
        end else begin
          cx_q <= '0;
          cy_q <= cy_q + 4'd1;
          if (ny_end > {1'b0, egh}) fh_q <= 5'd0;  // out of rows, give up
        end
      end
    end
  end

  assign busy = (state_q != FSM_IDLE);
  assign cfg_ready_o = (state_q == FSM_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DONE) |=> done_o)
    else $error("done state without strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");
endmodule
`default_nettype wire
